// ===== hw/rtl/mrpp_pkg.sv =====
// shared types and constants of the mqtt receive packet parser
package mrpp_pkg;

    // longest remaining-length field, in bytes (1 to 4)
    localparam int LEN_BYTES_MAX = 4;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_HANDLER_ENABLE = 3'd0;
    localparam logic [3:0] HANDLER_ENABLE_RESET = 4'hf;

    // parser phases
    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // packet types (high nibble of the type byte)
    localparam logic [3:0] T_CONNACK  = 4'd2;
    localparam logic [3:0] T_PUBLISH  = 4'd3;
    localparam logic [3:0] T_SUBACK   = 4'd9;
    localparam logic [3:0] T_UNSUBACK = 4'd11;
    localparam logic [3:0] T_PINGRESP = 4'd13;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_REFUSED    = 3'd1;
    localparam logic [2:0] ST_UNEXPECTED = 3'd2;
    localparam logic [2:0] ST_PUBLISH    = 3'd3;
    localparam logic [2:0] ST_PING       = 3'd4;
    localparam logic [2:0] ST_SUBACK     = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_TOPIC   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // handler enable bits
    localparam int EN_PUBLISH  = 0;
    localparam int EN_PING     = 1;
    localparam int EN_SUBACK   = 2;
    localparam int EN_UNSUBACK = 3;

    // suback return codes
    localparam logic [7:0] SUBACK_GRANTED = 8'h00;
    localparam logic [7:0] SUBACK_FAILED  = 8'h80;

    // shortest publish body, expected ack lengths
    localparam logic [27:0] PUBLISH_MIN_LEN = 28'd6;
    localparam logic [27:0] SUBACK_LEN      = 28'd3;
    localparam logic [27:0] ACK2_LEN        = 28'd2;
    localparam logic [27:0] TOPIC_HDR_LEN   = 28'd2;

    // one result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [2:0]  status;
        logic [15:0] packet_ident;
        logic        granted;
        logic [7:0]  topic_len;
        logic [27:0] payload_len;
    } t_result;

endpackage

// ===== hw/rtl/mrpp_if.sv =====
// stream interfaces for received bytes and parser results

// received byte channel
interface mrpp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// parser result channel
interface mrpp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [2:0]  status;
    logic [15:0] packet_ident;
    logic        granted;
    logic [7:0]  topic_len;
    logic [27:0] payload_len;

    modport source (output valid, output kind, output data_byte, output last,
                    output status, output packet_ident, output granted,
                    output topic_len, output payload_len, input ready);
    modport sink   (input valid, input kind, input data_byte, input last,
                    input status, input packet_ident, input granted,
                    input topic_len, input payload_len, output ready);
endinterface

// ===== hw/rtl/mrpp_cfg.sv =====
// apb register block holding the handler enable bits
module mrpp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrpp_pkg::PADDR_W-1:0] paddr,
    input  logic [mrpp_pkg::PDATA_W-1:0] pwdata,
    output logic [mrpp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [3:0]                  o_handler_enable
);
    import mrpp_pkg::*;

    logic [3:0] r_enable;
    logic       wr_hit;

    // register decode on the word index
    assign wr_hit = psel && penable && pwrite
                    && (paddr[PADDR_W-1] == ADDR_HANDLER_ENABLE[PADDR_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= HANDLER_ENABLE_RESET;
        end else if (wr_hit) begin
            r_enable <= pwdata[3:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == ADDR_HANDLER_ENABLE[PADDR_W-1]) begin
            prdata = {{(PDATA_W-4){1'b0}}, r_enable};
        end
    end

    assign pready           = 1'b1;
    assign o_handler_enable = r_enable;

endmodule

// ===== hw/rtl/mrpp_parse.sv =====
// input byte register and packet parsing state machine
module mrpp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_ready,
    input  logic [3:0]        i_handler_enable,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output mrpp_pkg::t_result o_res
);
    import mrpp_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       adv;

    // parser state
    logic [1:0]  r_phase,   n_phase;
    logic [3:0]  r_type,    n_type;
    logic [27:0] r_accum,   n_accum;
    logic [2:0]  r_lbc,     n_lbc;
    logic [27:0] r_bcount,  n_bcount;
    logic [7:0]  r_tls,     n_tls;
    logic [15:0] r_ident,   n_ident;
    logic [7:0]  r_code,    n_code;
    logic        r_bad,     n_bad;

    logic    res_valid;
    t_result res;

    // end-of-packet result built from the updated state
    function automatic t_result finish_res(
        input logic [3:0]  typ,
        input logic [3:0]  en,
        input logic [27:0] len,
        input logic [7:0]  tls,
        input logic [15:0] ident,
        input logic [7:0]  code,
        input logic        bad,
        input logic [1:0]  kind,
        input logic [7:0]  data
    );
        t_result r;
        r              = '0;
        r.kind         = KIND_STATUS;
        r.last         = 1'b1;
        r.status       = ST_OK;
        if (typ == T_PUBLISH && en[EN_PUBLISH]) begin
            if (len >= PUBLISH_MIN_LEN && !bad) begin
                r.kind        = kind;
                r.data_byte   = data;
                r.status      = ST_PUBLISH;
                r.topic_len   = tls;
                r.payload_len = len - {20'd0, tls} - TOPIC_HDR_LEN;
            end else begin
                r.status = ST_UNEXPECTED;
            end
        end else if (typ == T_PINGRESP && en[EN_PING]) begin
            r.status = ST_PING;
        end else if (typ == T_SUBACK && en[EN_SUBACK]) begin
            if (len != SUBACK_LEN || (code != SUBACK_GRANTED && code != SUBACK_FAILED)) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status       = ST_SUBACK;
                r.packet_ident = ident;
                r.granted      = (code == SUBACK_GRANTED);
            end
        end else if (typ == T_UNSUBACK && en[EN_UNSUBACK]) begin
            if (len != ACK2_LEN) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status       = ST_SUBACK;
                r.packet_ident = ident;
            end
        end else if (typ == T_CONNACK) begin
            if (len != ACK2_LEN) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status = (code != 8'd0) ? ST_REFUSED : ST_OK;
            end
        end
        return r;
    endfunction

    // a byte moves on whenever the result register can take its beat
    assign adv     = r_in_valid && i_res_ready;
    assign o_ready = !r_in_valid || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    // next state and result for the registered byte
    always_comb begin
        logic [7:0]  b;
        logic        pub_act;
        logic        stream;
        logic [1:0]  kind;
        logic        is_last;
        logic [5:0]  shamt;
        b         = r_in_byte;
        n_phase   = r_phase;
        n_type    = r_type;
        n_accum   = r_accum;
        n_lbc     = r_lbc;
        n_bcount  = r_bcount;
        n_tls     = r_tls;
        n_ident   = r_ident;
        n_code    = r_code;
        n_bad     = r_bad;
        res_valid = 1'b0;
        res       = '0;
        pub_act   = (r_type == T_PUBLISH) && i_handler_enable[EN_PUBLISH];
        stream    = 1'b0;
        kind      = KIND_STATUS;
        is_last   = 1'b0;
        shamt     = 6'd0;
        case (r_phase)
            PH_LEN: begin
                // length group, low seven bits first
                if (r_lbc < 3'd4) begin
                    shamt   = 6'(r_lbc[1:0]) * 6'd7;
                    n_accum = r_accum | (28'(b[6:0]) << shamt);
                end
                n_lbc = r_lbc + 3'd1;
                if (!b[7]) begin
                    if (n_accum == 28'd0) begin
                        n_phase   = PH_TYPE;
                        res_valid = 1'b1;
                        res       = finish_res(r_type, i_handler_enable, n_accum, r_tls,
                                               r_ident, r_code, r_bad, KIND_STATUS, 8'd0);
                    end else begin
                        n_phase  = PH_BODY;
                        n_bcount = 28'd0;
                    end
                end else if (n_lbc >= 3'(LEN_BYTES_MAX)) begin
                    // overlong length field
                    n_phase    = PH_TYPE;
                    res_valid  = 1'b1;
                    res.kind   = KIND_STATUS;
                    res.last   = 1'b1;
                    res.status = ST_UNEXPECTED;
                end
            end
            PH_BODY: begin
                n_bcount = r_bcount + 28'd1;
                is_last  = (n_bcount == r_accum);
                if (pub_act) begin
                    // topic length low byte, then streamed topic and payload
                    if (r_bcount == 28'd1) begin
                        n_tls = b;
                        n_bad = (28'(b) + TOPIC_HDR_LEN) > r_accum;
                    end else if (r_bcount >= 28'd2 && r_accum >= PUBLISH_MIN_LEN && !r_bad) begin
                        stream = 1'b1;
                        kind   = (r_bcount < (28'(r_tls) + TOPIC_HDR_LEN)) ?
                                 KIND_TOPIC : KIND_PAYLOAD;
                    end
                    if (is_last) begin
                        n_phase   = PH_TYPE;
                        res_valid = 1'b1;
                        res       = finish_res(r_type, i_handler_enable, r_accum, n_tls,
                                               r_ident, r_code, n_bad, kind,
                                               stream ? b : 8'd0);
                    end else if (stream) begin
                        res_valid     = 1'b1;
                        res.kind      = kind;
                        res.data_byte = b;
                    end
                end else begin
                    // identifier and return code capture
                    if (r_bcount == 28'd0) begin
                        n_ident = {b, 8'd0};
                    end else if (r_bcount == 28'd1) begin
                        n_ident = {r_ident[15:8], b};
                    end
                    if (r_bcount == ((r_type == T_CONNACK) ? 28'd1 : 28'd2)) begin
                        n_code = b;
                    end
                    if (is_last) begin
                        n_phase   = PH_TYPE;
                        res_valid = 1'b1;
                        res       = finish_res(r_type, i_handler_enable, r_accum, r_tls,
                                               n_ident, n_code, r_bad, KIND_STATUS, 8'd0);
                    end
                end
            end
            default: begin
                // type byte opens a packet
                n_type   = b[7:4];
                n_accum  = 28'd0;
                n_lbc    = 3'd0;
                n_bcount = 28'd0;
                n_tls    = 8'd0;
                n_ident  = 16'd0;
                n_code   = 8'd0;
                n_bad    = 1'b0;
                n_phase  = PH_LEN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_type   <= 4'd0;
            r_accum  <= 28'd0;
            r_lbc    <= 3'd0;
            r_bcount <= 28'd0;
            r_tls    <= 8'd0;
            r_ident  <= 16'd0;
            r_code   <= 8'd0;
            r_bad    <= 1'b0;
        end else if (adv) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_accum  <= n_accum;
            r_lbc    <= n_lbc;
            r_bcount <= n_bcount;
            r_tls    <= n_tls;
            r_ident  <= n_ident;
            r_code   <= n_code;
            r_bad    <= n_bad;
        end
    end

    assign o_res_valid = adv && res_valid;
    assign o_res       = res;

endmodule

// ===== hw/rtl/mrpp_out_reg.sv =====
// result register between the parser and the result channel
module mrpp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mrpp_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    output mrpp_pkg::t_result o_res,
    input  logic              i_ready
);
    import mrpp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // free when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/mqtt_receive_packet_parser_top.sv =====
// top level of the mqtt receive packet parser
//
//  channel   dir  handshake        payload
//  i_rx      in   valid / ready    rx_byte
//  o_res     out  valid / ready    kind, data_byte, last, status, packet_ident,
//                                  granted, topic_len, payload_len
//  apb       in   psel / penable   handler_enable at byte address 0
//
// one byte is taken per cycle while the result register can move; a byte is
// held in the input register, is parsed by the state machine and its result
// beat lands in the result register, from which it goes onto the channel.
// a stalled result register holds the input register, and the input side
// keeps taking bytes as long as the result register can move.
// reset is synchronous, active low; the parser then waits for a type byte.
module mqtt_receive_packet_parser_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mrpp_rx_if.sink                      i_rx,
    mrpp_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mrpp_pkg::PADDR_W-1:0] paddr,
    input  logic [mrpp_pkg::PDATA_W-1:0] pwdata,
    output logic [mrpp_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import mrpp_pkg::*;

    logic    [3:0] handler_enable;
    logic          parse_valid;
    t_result       parse_res;
    logic          out_ready;
    logic          res_valid;
    t_result       res;

    // configuration register
    mrpp_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_handler_enable (handler_enable)
    );

    // parser
    mrpp_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_rx.valid),
        .i_byte           (i_rx.rx_byte),
        .o_ready          (i_rx.ready),
        .i_handler_enable (handler_enable),
        .i_res_ready      (out_ready),
        .o_res_valid      (parse_valid),
        .o_res            (parse_res)
    );

    // result register
    mrpp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (parse_valid),
        .i_res   (parse_res),
        .o_ready (out_ready),
        .o_valid (res_valid),
        .o_res   (res),
        .i_ready (o_res.ready)
    );

    // result beat onto the channel
    assign o_res.valid        = res_valid;
    assign o_res.kind         = res.kind;
    assign o_res.data_byte    = res.data_byte;
    assign o_res.last         = res.last;
    assign o_res.status       = res.status;
    assign o_res.packet_ident = res.packet_ident;
    assign o_res.granted      = res.granted;
    assign o_res.topic_len    = res.topic_len;
    assign o_res.payload_len  = res.payload_len;

endmodule
